[sv/skvt_pkg.sv]
// Shared definitions for the sorted key/value table.
// Operation and status codes, default sizes and the cell command bundle.
// No dependencies.
package skvt_pkg;

   localparam int unsigned CAPACITY_DEFAULT   = 16;
   localparam int unsigned KEY_WIDTH_DEFAULT  = 32;
   localparam int unsigned DATA_WIDTH_DEFAULT = 32;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_LOOKUP = 2'd1;
   localparam logic [1:0] FUNC_DELETE = 2'd2;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      logic compare;   // register the compare flags against the incoming key
      logic insert;    // open a slot at the sorted place, shift larger entries up
      logic remove;    // close the slot at the matching place, shift larger entries down
   } skvt_cmd_type;

endpackage

[sv/skvt_cell.sv]
// One slot of the sorted table: a stored key/data pair plus compare flags.
// Exchanges entries with its lower and upper neighbours on insert and delete.
// Depends on skvt_pkg.
module skvt_cell #(
   parameter int unsigned KEY_WIDTH  = skvt_pkg::KEY_WIDTH_DEFAULT,
   parameter int unsigned DATA_WIDTH = skvt_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  skvt_pkg::skvt_cmd_type cmd,
   input  logic                   valid,
   input  logic [KEY_WIDTH-1:0]   cmp_key,
   input  logic [KEY_WIDTH-1:0]   new_key,
   input  logic [DATA_WIDTH-1:0]  new_data,
   input  logic                   prev_ge,
   input  logic [KEY_WIDTH-1:0]   prev_key,
   input  logic [DATA_WIDTH-1:0]  prev_data,
   input  logic [KEY_WIDTH-1:0]   next_key,
   input  logic [DATA_WIDTH-1:0]  next_data,
   output logic [KEY_WIDTH-1:0]   key,
   output logic [DATA_WIDTH-1:0]  data,
   output logic                   ge,
   output logic                   hit,
   output logic [DATA_WIDTH-1:0]  hit_data
);
   import skvt_pkg::*;

   logic [KEY_WIDTH-1:0]  key_ff, key_in;
   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  ge_ff, ge_in;
   logic                  eq_ff, eq_in;
   logic                  at_pos;

   // An empty slot counts as not below any key, so the flags rise once along the row.
   assign ge_in  = cmd.compare ? (!valid || (key_ff >= cmp_key)) : ge_ff;
   assign eq_in  = cmd.compare ? (key_ff == cmp_key) : eq_ff;
   assign at_pos = ge_ff && !prev_ge;

   always_comb begin
      key_in  = key_ff;
      data_in = data_ff;
      if (cmd.insert && ge_ff) begin
         key_in  = at_pos ? new_key  : prev_key;
         data_in = at_pos ? new_data : prev_data;
      end else if (cmd.remove && ge_ff) begin
         key_in  = next_key;
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      data_ff <= data_in;
      ge_ff   <= ge_in;
      eq_ff   <= eq_in;
   end

   assign key      = key_ff;
   assign data     = data_ff;
   assign ge       = ge_ff;
   assign hit      = at_pos && eq_ff && valid;
   assign hit_data = hit ? data_ff : '0;

endmodule

[sv/sorted_key_value_table_core.sv]
// Top level of the sorted key/value table: controller, row of slot cells, result register.
// Depends on skvt_pkg and skvt_cell.
//
// Keeps up to CAPACITY key/data pairs in ascending unsigned key order in a row of
// cells, one pair per cell, and serves one operation per request transaction:
// insert (refused with status 1 on a duplicate key, status 2 when the table is
// full), lookup (data returned with status 0, or status 1 and zero data when the
// key is absent) and delete (status 1 when absent). Each request gives exactly one
// response transaction carrying the status and the entry count after the operation.
// A request is handled in order: in the cycle it is accepted every cell compares the
// key against its own entry and registers the result, and in the next cycle the
// row locates the sorted position, all cells shift by one slot together where
// needed and the response is loaded. No new request is taken while one is being
// applied; the response register frees the request side as soon as the pending
// response is taken. Table contents are not cleared by reset; only the entry
// count is, so slots above the count are never consulted.
module sorted_key_value_table_core #(
   parameter int unsigned CAPACITY   = skvt_pkg::CAPACITY_DEFAULT,
   parameter int unsigned KEY_WIDTH  = skvt_pkg::KEY_WIDTH_DEFAULT,
   parameter int unsigned DATA_WIDTH = skvt_pkg::DATA_WIDTH_DEFAULT,
   localparam int unsigned COUNT_WIDTH = $clog2(CAPACITY + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_func,
   input  logic [KEY_WIDTH-1:0]   req_key,
   input  logic [DATA_WIDTH-1:0]  req_data_in,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [DATA_WIDTH-1:0]  rsp_found_data,
   output logic [COUNT_WIDTH-1:0] rsp_entry_count
);
   import skvt_pkg::*;

   // Controller states.
   localparam logic S_IDLE  = 1'b0;
   localparam logic S_APPLY = 1'b1;

   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(CAPACITY);

   logic                   state_ff, state_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [1:0]             func_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [DATA_WIDTH-1:0]  data_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             status_ff, status_in;
   logic [DATA_WIDTH-1:0]  found_ff, found_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff;

   logic                   req_fire;
   skvt_cmd_type           cmd;

   // Per-cell wiring; each element is driven by one cell only.
   logic [KEY_WIDTH-1:0]   cell_key      [CAPACITY];
   logic [DATA_WIDTH-1:0]  cell_data     [CAPACITY];
   logic                   cell_ge       [CAPACITY];
   logic                   cell_hit      [CAPACITY];
   logic [DATA_WIDTH-1:0]  cell_hit_data [CAPACITY];

   logic                   hit;
   logic [DATA_WIDTH-1:0]  hit_data;

   // Accept a request only when idle and the response register is free by the next edge.
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   // At most one cell flags a hit: the one at the sorted position.
   always_comb begin
      hit      = 1'b0;
      hit_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit      = hit | cell_hit[i];
         hit_data = hit_data | cell_hit_data[i];
      end
   end

   // Decide the operation in the apply cycle and drive the row.
   always_comb begin
      cmd.compare = req_fire;
      cmd.insert  = 1'b0;
      cmd.remove  = 1'b0;
      count_in    = count_ff;
      status_in   = STATUS_MISS;
      found_in    = '0;
      if (state_ff == S_APPLY) begin
         case (func_ff)
            FUNC_INSERT: begin
               if (hit) begin
                  status_in = STATUS_MISS;
               end else if (count_ff == FULL_COUNT) begin
                  status_in = STATUS_FULL;
               end else begin
                  cmd.insert = 1'b1;
                  count_in   = count_ff + COUNT_WIDTH'(1);
                  status_in  = STATUS_OK;
               end
            end
            FUNC_LOOKUP: begin
               if (hit) begin
                  status_in = STATUS_OK;
                  found_in  = hit_data;
               end
            end
            FUNC_DELETE: begin
               if (hit) begin
                  cmd.remove = 1'b1;
                  count_in   = count_ff - COUNT_WIDTH'(1);
                  status_in  = STATUS_OK;
               end
            end
            default: begin
               status_in = STATUS_MISS;
            end
         endcase
      end
   end

   // Advance the controller; the apply state follows every accepted request.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the request payload for the apply cycle.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff <= req_func;
         key_ff  <= req_key;
         data_ff <= req_data_in;
      end
   end

   // Load the response at the end of the apply cycle.
   always_ff @(posedge clock) begin
      if (state_ff == S_APPLY) begin
         status_ff    <= status_in;
         found_ff     <= found_in;
         rsp_count_ff <= count_in;
      end
   end

   // Row of cells; cell 0 sees a low flag and the request below, the top itself above.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                  prev_ge;
      logic [KEY_WIDTH-1:0]  prev_key;
      logic [DATA_WIDTH-1:0] prev_data;
      logic [KEY_WIDTH-1:0]  next_key;
      logic [DATA_WIDTH-1:0] next_data;
      logic                  valid;

      if (i == 0) begin : g_first
         assign prev_ge   = 1'b0;
         assign prev_key  = key_ff;
         assign prev_data = data_ff;
      end else begin : g_inner_lo
         assign prev_ge   = cell_ge[i-1];
         assign prev_key  = cell_key[i-1];
         assign prev_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_key  = cell_key[i];
         assign next_data = cell_data[i];
      end else begin : g_inner_hi
         assign next_key  = cell_key[i+1];
         assign next_data = cell_data[i+1];
      end

      assign valid = COUNT_WIDTH'(i) < count_ff;

      skvt_cell #(
         .KEY_WIDTH  (KEY_WIDTH),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .valid     (valid),
         .cmp_key   (req_key),
         .new_key   (key_ff),
         .new_data  (data_ff),
         .prev_ge   (prev_ge),
         .prev_key  (prev_key),
         .prev_data (prev_data),
         .next_key  (next_key),
         .next_data (next_data),
         .key       (cell_key[i]),
         .data      (cell_data[i]),
         .ge        (cell_ge[i]),
         .hit       (cell_hit[i]),
         .hit_data  (cell_hit_data[i])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found_data  = found_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

[sv/skvt_checker.sv]
// Port-level checks for the sorted key/value table, bound to the top level.
// Depends on skvt_pkg and sorted_key_value_table_core.
module skvt_checker #(
   parameter int unsigned CAPACITY   = skvt_pkg::CAPACITY_DEFAULT,
   parameter int unsigned DATA_WIDTH = skvt_pkg::DATA_WIDTH_DEFAULT,
   localparam int unsigned COUNT_WIDTH = $clog2(CAPACITY + 1)
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [1:0]             rsp_status,
   input logic [DATA_WIDTH-1:0]  rsp_found_data,
   input logic [COUNT_WIDTH-1:0] rsp_entry_count
);
   import skvt_pkg::*;

   // Hold a stalled response transaction.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_found_data) && $stable(rsp_entry_count))
      else $error("stalled response changed");

   // Drop ready in the cycle after a request transaction while it is applied.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted during apply cycle");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> rsp_entry_count == COUNT_WIDTH'(CAPACITY))
      else $error("full status with table not full");

   a_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_found_data != '0) |-> rsp_status == STATUS_OK)
      else $error("data returned without success");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= COUNT_WIDTH'(CAPACITY))
      else $error("entry count above capacity");

endmodule

bind sorted_key_value_table_core skvt_checker #(
   .CAPACITY   (CAPACITY),
   .DATA_WIDTH (DATA_WIDTH)
) u_skvt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_found_data  (rsp_found_data),
   .rsp_entry_count (rsp_entry_count)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for sorted_key_value_table_core: directed and random insert, lookup
// and delete traffic checked against a behavioural table model. Depends on skvt_pkg and the core.
module tb_top;
   import skvt_pkg::*;

   localparam int unsigned CAP     = CAPACITY_DEFAULT;
   localparam int unsigned KEY_W   = KEY_WIDTH_DEFAULT;
   localparam int unsigned DATA_W  = DATA_WIDTH_DEFAULT;
   localparam int unsigned COUNT_W = $clog2(CAP + 1);

   // The spare operation code: the block must leave the table alone and answer a miss.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam int unsigned POOL_SIZE = 24;
   localparam int unsigned SEGMENTS  = 8;
   localparam int unsigned SEG_ITEMS = 119;

   typedef struct {
      logic [1:0]        func;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] data;
      int unsigned       idle_pct;
      int unsigned       stall_pct;
      bit                drain;
   } table_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [DATA_W-1:0]  found;
      logic [COUNT_W-1:0] count;
   } table_rsp_type;

   logic                clock;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_ready;
   logic [1:0]          req_func        = FUNC_LOOKUP;
   logic [KEY_W-1:0]    req_key         = '0;
   logic [DATA_W-1:0]   req_data_in     = '0;
   logic                rsp_valid;
   logic                rsp_ready       = 1'b0;
   logic [1:0]          rsp_status;
   logic [DATA_W-1:0]   rsp_found_data;
   logic [COUNT_W-1:0]  rsp_entry_count;

   // Shadow copy of the table: slots below entry_cnt are live and ascending.
   logic [KEY_W-1:0]    key_tab [CAP];
   logic [DATA_W-1:0]   data_tab [CAP];
   int unsigned         entry_cnt = 0;

   table_req_type       req_backlog_q [$];
   table_rsp_type       resp_due_q [$];
   table_req_type       next_req;
   int unsigned         rsp_stall_pct = 0;
   int unsigned         fail_count    = 0;

   // Shaping applied to items as they are queued.
   int unsigned         gen_idle_pct  = 0;
   int unsigned         gen_stall_pct = 0;
   bit                  gen_drain     = 1'b0;
   logic [KEY_W-1:0]    key_pool [POOL_SIZE];

   sorted_key_value_table_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_key         (req_key),
      .req_data_in     (req_data_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_data  (rsp_found_data),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Apply one operation to the shadow table and return the response it should give.
   function automatic table_rsp_type table_apply(input logic [1:0] func,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [DATA_W-1:0] data);
      int unsigned   pos;
      bit            hit;
      table_rsp_type rsp;
      rsp.status = STATUS_MISS;
      rsp.found  = '0;
      // Find the first live slot whose key is not below the incoming key.
      pos = entry_cnt;
      for (int i = int'(entry_cnt) - 1; i >= 0; i--) begin
         if (key_tab[i] >= key) pos = unsigned'(i);
      end
      hit = (pos < entry_cnt) && (key_tab[pos] == key);
      case (func)
         FUNC_INSERT: begin
            if (hit) begin
               rsp.status = STATUS_MISS;
            end else if (entry_cnt >= CAP) begin
               rsp.status = STATUS_FULL;
            end else begin
               // Open the slot by moving every larger entry up one place.
               for (int i = int'(entry_cnt); i > int'(pos); i--) begin
                  key_tab[i]  = key_tab[i-1];
                  data_tab[i] = data_tab[i-1];
               end
               key_tab[pos]  = key;
               data_tab[pos] = data;
               entry_cnt++;
               rsp.status = STATUS_OK;
            end
         end
         FUNC_LOOKUP: begin
            if (hit) begin
               rsp.status = STATUS_OK;
               rsp.found  = data_tab[pos];
            end
         end
         FUNC_DELETE: begin
            if (hit) begin
               // Close the gap by moving every larger entry down one place.
               for (int i = int'(pos); i + 1 < int'(entry_cnt); i++) begin
                  key_tab[i]  = key_tab[i+1];
                  data_tab[i] = data_tab[i+1];
               end
               entry_cnt--;
               rsp.status = STATUS_OK;
            end
         end
         default: ;
      endcase
      rsp.count = entry_cnt[COUNT_W-1:0];
      return rsp;
   endfunction

   task automatic queue_req(input logic [1:0] func, input logic [KEY_W-1:0] key,
                            input logic [DATA_W-1:0] data);
      table_req_type r;
      r.func      = func;
      r.key       = key;
      r.data      = data;
      r.idle_pct  = gen_idle_pct;
      r.stall_pct = gen_stall_pct;
      r.drain     = gen_drain;
      gen_drain   = 1'b0;
      req_backlog_q.push_back(r);
   endtask

   // Mostly keys from the shared pool, so that hits, duplicates and a full table occur.
   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(99) < 85) return key_pool[$urandom_range(POOL_SIZE - 1)];
      return $urandom;
   endfunction

   // Driver: present the backlog head, honouring idle gaps and drain points.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            resp_due_q.push_back(table_apply(req_func, req_key, req_data_in));
         end
         if (!req_valid || req_ready) begin
            if (req_backlog_q.size() != 0 &&
                !(req_backlog_q[0].drain && resp_due_q.size() != 0) &&
                $urandom_range(99) >= req_backlog_q[0].idle_pct) begin
               next_req      = req_backlog_q.pop_front();
               req_valid     <= 1'b1;
               req_func      <= next_req.func;
               req_key       <= next_req.key;
               req_data_in   <= next_req.data;
               rsp_stall_pct <= next_req.stall_pct;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_response();
      table_rsp_type due;
      if (resp_due_q.size() == 0) begin
         $error("response transaction with nothing outstanding: status %0d data %h count %0d",
                rsp_status, rsp_found_data, rsp_entry_count);
         fail_count++;
      end else begin
         due = resp_due_q.pop_front();
         if (rsp_status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, rsp_status);
            fail_count++;
         end
         if (rsp_found_data !== due.found) begin
            $error("found_data: expected %h, got %h", due.found, rsp_found_data);
            fail_count++;
         end
         if (rsp_entry_count !== due.count) begin
            $error("entry_count: expected %0d, got %0d", due.count, rsp_entry_count);
            fail_count++;
         end
      end
   endtask

   // Monitor: check every accepted response and stall at the current rate.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_response();
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin : stimulus
      int unsigned ins_pct;
      int unsigned r;
      logic [1:0]  func;
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = {1'b0, {(KEY_W-1){1'b1}}};
      key_pool[3] = {1'b1, {(KEY_W-1){1'b0}}};
      for (int i = 4; i < POOL_SIZE; i++) begin
         // Pair some keys as near neighbours to exercise the ordering.
         key_pool[i] = (i % 3 == 0) ? key_pool[i-1] + 1 : $urandom;
      end

      // Directed part, no idling: empty table, extremes, duplicates, a full table.
      queue_req(FUNC_LOOKUP, '0, '1);
      queue_req(FUNC_DELETE, 32'h0000_0005, '0);
      queue_req(FUNC_INSERT, '1, '1);
      queue_req(FUNC_INSERT, '0, '0);
      queue_req(FUNC_INSERT, 32'h8000_0000, 32'hA5A5_5A5A);
      queue_req(FUNC_INSERT, '1, 32'h1234_5678);
      queue_req(FUNC_LOOKUP, '1, '0);
      queue_req(FUNC_LOOKUP, 32'h0001_2345, '1);
      queue_req(FUNC_UNUSED, '0, '1);
      queue_req(FUNC_DELETE, 32'h8000_0000, '0);
      for (int i = 0; i < CAP - 2; i++) queue_req(FUNC_INSERT, $urandom | 1, $urandom);
      queue_req(FUNC_INSERT, 32'h8000_0000, '1);
      queue_req(FUNC_INSERT, '0, 32'hDEAD_BEEF);

      // Random part: segments cycle through the idling modes, alternating between
      // insert-heavy traffic that fills the table and delete-heavy traffic that drains it.
      for (int s = 0; s < SEGMENTS; s++) begin
         case (s % 4)
            0: begin gen_idle_pct = 0;  gen_stall_pct = 0;  end
            1: begin gen_idle_pct = 71; gen_stall_pct = 0;  end
            2: begin gen_idle_pct = 0;  gen_stall_pct = 71; end
            default: begin gen_idle_pct = 23; gen_stall_pct = 23; end
         endcase
         // Hold the first item of each segment until the table has answered everything.
         gen_drain = 1'b1;
         ins_pct   = (s % 2 == 0) ? $urandom_range(55, 75) : $urandom_range(10, 25);
         for (int n = 0; n < SEG_ITEMS; n++) begin
            r = $urandom_range(99);
            if (r < 3) func = FUNC_UNUSED;
            else if (r < 3 + ins_pct) func = FUNC_INSERT;
            else if (s % 2 == 0) func = $urandom_range(1) ? FUNC_LOOKUP : FUNC_DELETE;
            else func = ($urandom_range(99) < 30) ? FUNC_LOOKUP : FUNC_DELETE;
            queue_req(func, pick_key(), $urandom);
         end
      end

      // Wait for the backlog and every outstanding response, then let the pipe settle.
      while (req_backlog_q.size() != 0 || req_valid || resp_due_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && resp_due_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

[sim.f]
sv/skvt_pkg.sv
sv/skvt_cell.sv
sv/sorted_key_value_table_core.sv
sv/skvt_checker.sv
tb/tb_top.sv
